// ===== sv/utf8_xml_text_escaper_top_assert.svh =====
// assertion macros shared by the escaper top level
`ifndef UTF8_XML_TEXT_ESCAPER_TOP_ASSERT_SVH
`define UTF8_XML_TEXT_ESCAPER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UTXE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utxe assertion failed");

// next-cycle implication, checked out of reset
`define UTXE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utxe assertion failed");

`endif

// ===== sv/utxe_pkg.sv =====
package utxe_pkg;

  // fault classes reported in an error item
  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrMalformed = 2'd1,
    ErrForbidden = 2'd2
  } err_kind_e;

  // one decoded character or one fault, handed from decoder to emitter
  typedef struct packed {
    logic [20:0] code;
    logic [1:0]  cls;
    err_kind_e   err;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int unsigned JobQueueDepth = 4;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;

  localparam logic [20:0] Min2Byte     = 21'h00080;
  localparam logic [20:0] Min3Byte     = 21'h00800;
  localparam logic [20:0] Min4Byte     = 21'h10000;
  localparam logic [20:0] SurrogateLo  = 21'h0D800;
  localparam logic [20:0] SurrogateHi  = 21'h0DFFF;
  localparam logic [20:0] NonCharFffe  = 21'h0FFFE;
  localparam logic [20:0] NonCharFfff  = 21'h0FFFF;
  localparam logic [20:0] CodeMax      = 21'h10FFFF;
  localparam logic [20:0] ControlLimit = 21'h00020;
  localparam logic [20:0] CodeTab      = 21'h00009;
  localparam logic [20:0] CodeLf       = 21'h0000A;
  localparam logic [20:0] CodeCr       = 21'h0000D;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChQuot = 8'h22;

endpackage

// ===== sv/utxe_front.sv =====
module utxe_front
  import utxe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] part_q, part_d;
  logic [1:0]  cls_q, cls_d;
  logic        failed_q, failed_d;

  logic        accept;
  logic [20:0] cont_code;

  function automatic logic value_ok(logic [20:0] code, logic [1:0] cls);
    logic ok;
    ok = 1'b1;
    unique case (cls)
      2'd1:    if (code < Min2Byte) ok = 1'b0;
      2'd2:    if (code < Min3Byte) ok = 1'b0;
      2'd3:    if (code < Min4Byte) ok = 1'b0;
      default: ok = 1'b1;
    endcase
    if (code < ControlLimit && code != CodeTab && code != CodeLf && code != CodeCr)
      ok = 1'b0;
    if (code >= SurrogateLo && code <= SurrogateHi) ok = 1'b0;
    if (code == NonCharFffe || code == NonCharFfff) ok = 1'b0;
    if (code > CodeMax) ok = 1'b0;
    return ok;
  endfunction

  assign s_tready_o = !q_status_i.full;
  assign accept     = s_tvalid_i && s_tready_o;
  assign cont_code  = {part_q[14:0], s_tdata_i[5:0]};

  always_comb begin
    logic [20:0] code;
    logic [1:0]  cls;
    logic [1:0]  pend;
    logic        complete;
    err_kind_e   kind;

    pend_d   = pend_q;
    part_d   = part_q;
    cls_d    = cls_q;
    failed_d = failed_q;
    push_o   = 1'b0;
    code     = part_q;
    cls      = cls_q;
    pend     = pend_q;
    complete = 1'b0;
    kind     = ErrNone;

    if (accept) begin
      if (failed_q) begin
        if (s_tlast_i) begin
          pend_d   = '0;
          part_d   = '0;
          cls_d    = '0;
          failed_d = 1'b0;
        end
      end else begin
        if (pend_q == 2'd0) begin
          priority if (s_tdata_i < AsciiLimit) begin
            code     = {13'd0, s_tdata_i};
            cls      = 2'd0;
            complete = 1'b1;
          end else if (s_tdata_i >= Lead2Min && s_tdata_i <= Lead2Max) begin
            code = {16'd0, s_tdata_i[4:0]};
            cls  = 2'd1;
            pend = 2'd1;
          end else if (s_tdata_i >= Lead3Min && s_tdata_i <= Lead3Max) begin
            code = {17'd0, s_tdata_i[3:0]};
            cls  = 2'd2;
            pend = 2'd2;
          end else if (s_tdata_i >= Lead4Min && s_tdata_i <= Lead4Max) begin
            code = {18'd0, s_tdata_i[2:0]};
            cls  = 2'd3;
            pend = 2'd3;
          end else begin
            kind = ErrMalformed;
          end
        end else if (s_tdata_i[7:6] != 2'b10) begin
          kind = ErrMalformed;
        end else begin
          code     = cont_code;
          pend     = pend_q - 2'd1;
          complete = (pend_q == 2'd1);
        end

        if (kind == ErrNone && complete && !value_ok(code, cls)) kind = ErrForbidden;
        if (kind == ErrNone && !complete && s_tlast_i) kind = ErrMalformed;

        if (kind != ErrNone) begin
          push_o   = 1'b1;
          pend_d   = '0;
          part_d   = '0;
          cls_d    = '0;
          failed_d = !s_tlast_i;
        end else if (complete) begin
          push_o = 1'b1;
          pend_d = '0;
          part_d = '0;
          cls_d  = '0;
        end else begin
          pend_d = pend;
          part_d = code;
          cls_d  = cls;
        end
      end
    end

    job_o.code = code;
    job_o.cls  = cls;
    job_o.err  = kind;
    job_o.last = s_tlast_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      part_q   <= '0;
      cls_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      part_q   <= part_d;
      cls_q    <= cls_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ===== sv/utxe_fifo.sv =====
module utxe_fifo
  import utxe_pkg::*;
#(
  parameter int unsigned Depth = JobQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/utxe_back.sv =====
module utxe_back
  import utxe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_status_t  q_status_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_byte_o,
  output logic       m_has_o,
  output logic       m_run_last_o,
  output logic       m_done_o,
  output err_kind_e  m_kind_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       has_q, run_q, done_q;
  err_kind_e  kind_q;

  logic       load, is_final;
  logic [2:0] len;
  logic [7:0] byte_nx;

  function automatic logic [2:0] job_len(job_t j);
    logic [2:0] n;
    n = 3'd1;
    if (j.err == ErrNone) begin
      if (j.cls != 2'd0) begin
        n = {1'b0, j.cls} + 3'd1;
      end else begin
        unique case (j.code[7:0])
          ChAmp:        n = 3'd5;
          ChLt, ChGt:   n = 3'd4;
          ChQuot:       n = 3'd6;
          default:      n = 3'd1;
        endcase
      end
    end
    return n;
  endfunction

  // entity text for the four escaped characters, plain byte otherwise
  function automatic logic [7:0] esc_byte(logic [7:0] ch, logic [2:0] idx);
    logic [7:0] r;
    r = ch;
    unique case (ch)
      ChAmp: begin
        unique case (idx)
          3'd0:    r = ChAmp;
          3'd1:    r = "a";
          3'd2:    r = "m";
          3'd3:    r = "p";
          default: r = ";";
        endcase
      end
      ChLt: begin
        unique case (idx)
          3'd0:    r = ChAmp;
          3'd1:    r = "l";
          3'd2:    r = "t";
          default: r = ";";
        endcase
      end
      ChGt: begin
        unique case (idx)
          3'd0:    r = ChAmp;
          3'd1:    r = "g";
          3'd2:    r = "t";
          default: r = ";";
        endcase
      end
      ChQuot: begin
        unique case (idx)
          3'd0:    r = ChAmp;
          3'd1:    r = "q";
          3'd2:    r = "u";
          3'd3:    r = "o";
          3'd4:    r = "t";
          default: r = ";";
        endcase
      end
      default: r = ch;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] job_byte(job_t j, logic [2:0] idx);
    logic [1:0] d;
    logic [7:0] r;
    d = j.cls - idx[1:0];
    r = '0;
    if (j.cls == 2'd0) begin
      r = esc_byte(j.code[7:0], idx);
    end else if (idx == 3'd0) begin
      unique case (j.cls)
        2'd1:    r = {3'b110, j.code[10:6]};
        2'd2:    r = {4'b1110, j.code[15:12]};
        default: r = {5'b11110, j.code[20:18]};
      endcase
    end else begin
      unique case (d)
        2'd0:    r = {2'b10, j.code[5:0]};
        2'd1:    r = {2'b10, j.code[11:6]};
        default: r = {2'b10, j.code[17:12]};
      endcase
    end
    return r;
  endfunction

  assign len      = job_len(job_i);
  assign byte_nx  = job_byte(job_i, idx_q);
  assign is_final = (idx_q == len - 3'd1);
  assign load     = !q_status_i.empty && (!valid_q || m_tready_i);
  assign pop_o    = load && is_final;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_final ? 3'd0 : idx_q + 3'd1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (job_i.err != ErrNone) begin
        byte_q <= '0;
        has_q  <= 1'b0;
        run_q  <= 1'b1;
        done_q <= 1'b1;
        kind_q <= job_i.err;
      end else begin
        byte_q <= byte_nx;
        has_q  <= 1'b1;
        run_q  <= is_final;
        done_q <= is_final && job_i.last;
        kind_q <= ErrNone;
      end
    end
  end

  assign m_tvalid_o   = valid_q;
  assign m_byte_o     = byte_q;
  assign m_has_o      = has_q;
  assign m_run_last_o = run_q;
  assign m_done_o     = done_q;
  assign m_kind_o     = kind_q;

endmodule

// ===== sv/utf8_xml_text_escaper_top.sv =====
// path: an accepted byte that completes a character is written into the job queue, and its
//   first output item is then loaded from the queue into the output register
// throughput: one input byte per cycle while the job queue is not full; a byte giving k
//   output items (k is 1 to 6) holds the emitter until all k are out, and the queue absorbs that
// reset: asynchronous, active low; clears decoder state, queue pointers and output valid
`include "utf8_xml_text_escaper_top_assert.svh"

module utf8_xml_text_escaper_top
  import utxe_pkg::*;
#(
  parameter int unsigned QueueDepth = JobQueueDepth  // jobs between decoder and emitter
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input bytes of the text
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // text_last
  // escaped output items
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser_o,   // [0] has_byte, [1] run_last, [3:2] error_kind
  output logic       m_axis_tlast_o    // text_done
);

  // decoder to queue
  logic      push;
  job_t      push_job;
  // queue to emitter
  logic      pop;
  job_t      head_job;
  q_status_t q_status;

  logic      run_last;
  logic      has_byte;
  err_kind_e err_kind;

  // front: utf-8 decode, value checks, one job per byte that produces output
  utxe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  // short job queue decoupling the two halves
  utxe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  // back: expands each job into utf-8 bytes, entity text or an error item
  utxe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .job_i        (head_job),
    .pop_o        (pop),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_byte_o     (m_axis_tdata_o),
    .m_has_o      (has_byte),
    .m_run_last_o (run_last),
    .m_done_o     (m_axis_tlast_o),
    .m_kind_o     (err_kind)
  );

  assign m_axis_tuser_o = {err_kind, run_last, has_byte};

  // the decoder never pushes into a full queue
  `UTXE_ASSERT_IMP(a_no_overflow, push, !q_status.full)
  // an error item closes its text and carries a fault class
  `UTXE_ASSERT_IMP(a_err_closes, m_axis_tvalid_o && !has_byte,
                   run_last && m_axis_tlast_o && err_kind != ErrNone)
  // data items carry no fault class
  `UTXE_ASSERT_IMP(a_data_clean, m_axis_tvalid_o && has_byte, err_kind == ErrNone)
  // end of text only on the last item of a byte
  `UTXE_ASSERT_IMP(a_done_on_run, m_axis_tvalid_o && m_axis_tlast_o, run_last)

endmodule

// ===== sim/escaped_stream_checker.sv =====
`timescale 1ns / 100ps

module escaped_stream_checker
  import utxe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_data_i,
  input  logic [3:0]  out_user_i,
  input  logic        out_last_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       run_end;
    logic       text_end;
    err_kind_e  kind;
  } esc_item_t;

  esc_item_t escaped_q[$];

  // decoder state of the model
  logic [1:0]  cont_left   = '0;
  logic [20:0] code_acc    = '0;
  logic [1:0]  seq_class   = '0;
  logic        text_failed = 1'b0;
  int unsigned mismatches  = 0;

  function automatic void clear_text();
    cont_left   = '0;
    code_acc    = '0;
    seq_class   = '0;
    text_failed = 1'b0;
  endfunction

  function automatic bit char_legal(logic [20:0] cp, logic [1:0] cls);
    logic [20:0] floor_cp;
    case (cls)
      2'd1:    floor_cp = Min2Byte;
      2'd2:    floor_cp = Min3Byte;
      2'd3:    floor_cp = Min4Byte;
      default: floor_cp = '0;
    endcase
    if (cp < floor_cp) return 1'b0;
    if (cp < ControlLimit && cp != CodeTab && cp != CodeLf && cp != CodeCr) return 1'b0;
    if (cp >= SurrogateLo && cp <= SurrogateHi) return 1'b0;
    if (cp == NonCharFffe || cp == NonCharFfff) return 1'b0;
    return cp <= CodeMax;
  endfunction

  // appends one predicted item at the tail
  function automatic void queue_item(esc_item_t it);
    escaped_q.insert(escaped_q.size(), it);
  endfunction

  function automatic void push_data(logic [7:0] b);
    esc_item_t it;
    it = '{data: b, has_data: 1'b1, run_end: 1'b0, text_end: 1'b0, kind: ErrNone};
    queue_item(it);
  endfunction

  function automatic void push_entity(string s);
    for (int i = 0; i < s.len(); i++) push_data(s[i]);
  endfunction

  function automatic void predict_escape(logic [7:0] b, logic lst);
    err_kind_e   fault;
    bit          done_char;
    int unsigned idx;
    esc_item_t   err_item;
    fault     = ErrNone;
    done_char = 1'b0;
    if (text_failed) begin
      if (lst) clear_text();
      return;
    end
    if (cont_left == 2'd0) begin
      if (b < AsciiLimit) begin
        code_acc  = 21'(b);
        seq_class = 2'd0;
        done_char = 1'b1;
      end else if (b >= Lead2Min && b <= Lead2Max) begin
        code_acc  = 21'(b[4:0]);
        seq_class = 2'd1;
        cont_left = 2'd1;
      end else if (b >= Lead3Min && b <= Lead3Max) begin
        code_acc  = 21'(b[3:0]);
        seq_class = 2'd2;
        cont_left = 2'd2;
      end else if (b >= Lead4Min && b <= Lead4Max) begin
        code_acc  = 21'(b[2:0]);
        seq_class = 2'd3;
        cont_left = 2'd3;
      end else begin
        fault = ErrMalformed;
      end
    end else if (b[7:6] != 2'b10) begin
      fault = ErrMalformed;
    end else begin
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      done_char = (cont_left == 2'd0);
    end

    if (fault == ErrNone && done_char && !char_legal(code_acc, seq_class)) fault = ErrForbidden;
    if (fault == ErrNone && !done_char && lst) fault = ErrMalformed;

    if (fault != ErrNone) begin
      err_item = '{data: 8'h00, has_data: 1'b0, run_end: 1'b1, text_end: 1'b1,
                   kind: fault};
      queue_item(err_item);
      clear_text();
      text_failed = !lst;
      return;
    end
    if (!done_char) return;

    if (seq_class == 2'd0) begin
      case (code_acc[7:0])
        ChAmp:   push_entity("&amp;");
        ChLt:    push_entity("&lt;");
        ChGt:    push_entity("&gt;");
        ChQuot:  push_entity("&quot;");
        default: push_data(code_acc[7:0]);
      endcase
    end else begin
      if (seq_class == 2'd3) begin
        push_data({5'b11110, code_acc[20:18]});
        push_data({2'b10, code_acc[17:12]});
      end
      if (seq_class == 2'd2) push_data({4'b1110, code_acc[15:12]});
      if (seq_class == 2'd1) push_data({3'b110, code_acc[10:6]});
      if (seq_class >= 2'd2) push_data({2'b10, code_acc[11:6]});
      push_data({2'b10, code_acc[5:0]});
    end
    idx = escaped_q.size() - 1;
    escaped_q[idx].run_end  = 1'b1;
    escaped_q[idx].text_end = lst;
    code_acc  = '0;
    seq_class = '0;
    if (lst) clear_text();
  endfunction

  function automatic string show_item(esc_item_t it);
    return $sformatf("data %h has %b run %b done %b kind %0d",
                     it.data, it.has_data, it.run_end, it.text_end, it.kind);
  endfunction

  always @(posedge clk_i) begin
    esc_item_t want;
    esc_item_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_escape(in_data_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        got = '{data: out_data_i, has_data: out_user_i[0], run_end: out_user_i[1],
                text_end: out_last_i, kind: err_kind_e'(out_user_i[3:2])};
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got %s", $time, show_item(got));
          mismatches++;
        end else begin
          want = escaped_q.pop_front();
          if (got !== want) begin
            $display("%0t: item mismatch, expected %s, got %s", $time,
                     show_item(want), show_item(got));
            mismatches++;
          end
        end
      end
    end
    pending_o = escaped_q.size();
    errors_o  = mismatches;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import utxe_pkg::*;

  localparam int unsigned CycleLimit  = 200000;  // far above the slowest legal run
  localparam int unsigned RandomBytes = 250;
  localparam int unsigned DrainCycles = 20;      // well above the pipeline latency

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned fail_count;
  int unsigned pending_count;

  // bytes of the text being assembled, sent as one frame
  logic [7:0] text_buf[$];

  utf8_xml_text_escaper_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  escaped_stream_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .in_last_i   (s_tlast),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .out_user_i  (m_tuser),
    .out_last_i  (m_tlast),
    .errors_o    (fail_count),
    .pending_o   (pending_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run guard: any hang ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // random continuation byte 10xxxxxx
  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // appends one byte to the text under construction
  task automatic add_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  // one input item; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // the whole buffer as one text, tlast on its final byte
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    bytes_sent += text_buf.size();
    text_buf.delete();
  endtask

  // sender holds off until every predicted item has come out
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // shortest utf-8 form of a code point
  task automatic encode_code(input logic [20:0] cp);
    if (cp < Min2Byte) begin
      add_byte(cp[7:0]);
    end else if (cp < Min3Byte) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < Min4Byte) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endtask

  // a character that is legal in xml text
  task automatic add_good_char();
    int unsigned pick;
    logic [20:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      encode_code(21'($urandom_range(32, 127)));
    end else if (pick < 52) begin
      case ($urandom_range(0, 3))
        0:       add_byte(ChAmp);
        1:       add_byte(ChLt);
        2:       add_byte(ChGt);
        default: add_byte(ChQuot);
      endcase
    end else if (pick < 56) begin
      case ($urandom_range(0, 2))
        0:       encode_code(CodeTab);
        1:       encode_code(CodeLf);
        default: encode_code(CodeCr);
      endcase
    end else if (pick < 70) begin
      encode_code(21'($urandom_range(Min2Byte, Min3Byte - 1)));
    end else if (pick < 85) begin
      // skip the surrogate block and the two non-characters at the top of the plane
      do cp = 21'($urandom_range(Min3Byte, Min4Byte - 1));
      while ((cp >= SurrogateLo && cp <= SurrogateHi) || cp == NonCharFffe || cp == NonCharFfff);
      encode_code(cp);
    end else begin
      encode_code(21'($urandom_range(Min4Byte, CodeMax)));
    end
  endtask

  // one fault of a random kind
  task automatic add_fault();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: add_byte(rand_cont());                                  // stray continuation
      1: begin                                                   // overlong two-byte lead
        add_byte(8'($urandom_range(8'h80 | 8'h40, Lead2Min - 1)));
        add_byte(rand_cont());
      end
      2: add_byte(8'($urandom_range(Lead4Max + 1, 8'hFF)));      // lead past f4
      3: begin                                                   // overlong three-byte
        add_byte(Lead3Min);
        add_byte(8'($urandom_range(8'h80, 8'h9F)));
        add_byte(rand_cont());
      end
      4: begin                                                   // overlong four-byte
        add_byte(Lead4Min);
        add_byte(8'($urandom_range(8'h80, 8'h8F)));
        add_byte(rand_cont());
        add_byte(rand_cont());
      end
      5: begin                                                   // surrogate
        add_byte(8'hED);
        add_byte(8'($urandom_range(8'hA0, 8'hBF)));
        add_byte(rand_cont());
      end
      6: begin                                                   // fffe or ffff
        add_byte(8'hEF);
        add_byte(8'hBF);
        add_byte(8'($urandom_range(8'hBE, 8'hBF)));
      end
      7: begin                                                   // above the code space
        add_byte(Lead4Max);
        add_byte(8'($urandom_range(8'h90, 8'hBF)));
        add_byte(rand_cont());
        add_byte(rand_cont());
      end
      8: begin                                                   // lead then a non-continuation
        add_byte(8'($urandom_range(Lead2Min, Lead4Max)));
        add_byte(8'($urandom_range(8'h00, 8'h7F)));
      end
      default: begin                                             // forbidden control
        do b = 8'($urandom_range(0, 31));
        while (b == 8'(CodeTab) || b == 8'(CodeLf) || b == 8'(CodeCr));
        add_byte(b);
      end
    endcase
  endtask

  // mostly well-formed texts, some with one fault, some pure noise
  task automatic build_text();
    int unsigned pick;
    int unsigned n_chars;
    int unsigned bad_at;
    pick    = $urandom_range(0, 99);
    n_chars = $urandom_range(1, 8);
    if (pick < 10) begin
      for (int i = 0; i < n_chars; i++) add_byte(8'($urandom_range(0, 255)));
    end else begin
      bad_at = (pick < 30) ? $urandom_range(0, n_chars - 1) : n_chars;
      for (int i = 0; i < n_chars; i++) begin
        if (i == bad_at) add_fault();
        else add_good_char();
      end
      // text cut off in the middle of a sequence
      if (pick >= 30 && pick < 36) begin
        add_byte(8'($urandom_range(Lead2Min, Lead4Max)));
        if (text_buf[text_buf.size() - 1] >= Lead3Min && $urandom_range(0, 1) == 1) begin
          add_byte(rand_cont());
        end
      end
    end
  endtask

  initial begin
    // known levels from time zero, reset held low before its release
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    bytes_sent  = 0;
    tx_idle_pct = 33;
    rx_idle_pct = 75;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: the four escaped characters and the allowed controls
    text_buf = '{ChAmp, ChLt, ChGt, ChQuot, 8'h09, 8'h0D, 8'h0A};
    send_text();
    // nul is a forbidden control, reported on the final byte
    text_buf = '{8'h00};
    send_text();
    // bad lead byte, then the rest of the text stays silent up to a silent end
    text_buf = '{8'hFF, 8'h41, 8'h42};
    send_text();
    // smallest two-byte character and the largest code point
    text_buf = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    // overlong three-byte form of zero
    text_buf = '{8'hE0, 8'h80, 8'h80};
    send_text();
    // missing continuation on the final byte
    text_buf = '{8'hE2, 8'h41};
    send_text();
    // sequence still open at the end of the text
    text_buf = '{8'hF0};
    send_text();
    // non-character ffff
    text_buf = '{8'hEF, 8'hBF, 8'hBF};
    send_text();
    hold_until_drained();

    // random texts over three idling phases, drained between phases
    bytes_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 33;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 33;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (bytes_sent < RandomBytes * (phase + 1) / 3) begin
        build_text();
        send_text();
      end
      hold_until_drained();
    end

    // let any stray item show up before the verdict
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/utxe_pkg.sv
sv/utxe_front.sv
sv/utxe_fifo.sv
sv/utxe_back.sv
sv/utf8_xml_text_escaper_top.sv
sim/escaped_stream_checker.sv
sim/testbench.sv
